FILE: design/address_keyed_wait_queue_unit_defines.svh
// assertion macros for the address keyed wait queue unit
// used by the top level only; sampled on clk_i, held off while rst_ni is low
`ifndef ADDRESS_KEYED_WAIT_QUEUE_UNIT_DEFINES_SVH
`define ADDRESS_KEYED_WAIT_QUEUE_UNIT_DEFINES_SVH

// property checked at every edge out of reset
`define AKWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define AKWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/akwq_pkg.sv
// shared constants, opcodes and controller/datapath bundles for the wait queue unit
// no dependencies
`default_nettype none

package akwq_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int NUM_THREADS = 32;
  localparam int HASH_SHIFT  = 4;
  localparam int KEY_W       = 64;

  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int THREAD_W = $clog2(NUM_THREADS);
  // link values run up to NUM_THREADS, which marks an empty chain
  localparam int LINK_W   = $clog2(NUM_THREADS + 1);
  localparam int COUNT_W  = LINK_W;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_THREADS);

  // stream packing
  localparam int IN_KEY_LSB   = 0;
  localparam int IN_TID_LSB   = KEY_W;
  localparam int IN_LIMIT_LSB = KEY_W + THREAD_W;
  localparam int IN_DATA_W    = ((KEY_W + THREAD_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_CNT_LSB  = THREAD_W;
  localparam int OUT_PAD_W    = ((THREAD_W + COUNT_W + 7) / 8) * 8 - THREAD_W - COUNT_W;
  localparam int OUT_DATA_W   = THREAD_W + COUNT_W + OUT_PAD_W;

  typedef enum logic {
    OP_WAIT = 1'b0,
    OP_WAKE = 1'b1
  } akwq_op_e;

  typedef struct packed {
    logic capture;    // latch item, read bucket head
    logic park;       // push thread on its chain
    logic walk_step;  // pop one link onto the release stack
    logic head_wb;    // write back the remaining chain head
    logic emit_rd;    // read release stack entry
    logic emit_ld;    // load a woken thread into the output register
    logic emit_none;  // load the nothing-woken result
  } akwq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic count_zero;
    logic emit_last;
    logic out_free;
  } akwq_sts_t;

endpackage

`default_nettype wire

FILE: design/akwq_ctrl.sv
// sequencer for the wait queue unit: park, chain walk and result emission
// depends on akwq_pkg
`default_nettype none

module akwq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  akwq_pkg::akwq_sts_t sts_i,
  output akwq_pkg::akwq_cmd_t cmd_o
);
  import akwq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARK,
    ST_WALK,
    ST_ERD,
    ST_ELD,
    ST_NONE
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.capture = 1'b1;
          state_d = (in_op_i == OP_WAKE) ? ST_WALK : ST_PARK;
        end
      end
      ST_PARK: begin
        cmd_o.park = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          cmd_o.head_wb = 1'b1;
          state_d = sts_i.count_zero ? ST_NONE : ST_ERD;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = ST_ELD;
      end
      ST_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d = sts_i.emit_last ? ST_IDLE : ST_ERD;
        end
      end
      ST_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

FILE: design/akwq_dp.sv
// datapath of the wait queue unit: head table, link table, release stack, output register
// depends on akwq_pkg; driven by akwq_ctrl
`default_nettype none

module akwq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  akwq_pkg::akwq_cmd_t             cmd_i,
  output akwq_pkg::akwq_sts_t             sts_o,
  input  logic [akwq_pkg::KEY_W-1:0]      in_key_i,
  input  logic [akwq_pkg::THREAD_W-1:0]   in_tid_i,
  input  logic [akwq_pkg::COUNT_W-1:0]    in_limit_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [akwq_pkg::THREAD_W-1:0]   out_thread_o,
  output logic                            out_none_o,
  output logic [akwq_pkg::COUNT_W-1:0]    out_count_o,
  output logic                            out_last_o
);
  import akwq_pkg::*;

  logic [LINK_W-1:0]   head_mem  [NUM_BUCKETS];
  logic [LINK_W-1:0]   link_mem  [NUM_THREADS];
  logic [THREAD_W-1:0] stack_mem [NUM_THREADS];
  logic [NUM_BUCKETS-1:0] head_vld_q;

  logic [BUCKET_W-1:0] in_bucket;
  logic [COUNT_W-1:0]  in_limit_sat;

  logic [BUCKET_W-1:0] bucket_q;
  logic [THREAD_W-1:0] tid_q;
  logic [COUNT_W-1:0]  limit_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  emit_q;
  logic                use_link_q;
  logic [LINK_W-1:0]   head_rd_q;
  logic [LINK_W-1:0]   link_rd_q;
  logic [THREAD_W-1:0] stack_rd_q;

  logic [THREAD_W-1:0] out_thread_q;
  logic                out_none_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_last_q;
  logic                out_valid_q;

  logic [LINK_W-1:0]   cur;
  logic                cur_end;
  logic                head_we;
  logic [LINK_W-1:0]   head_wdata;
  logic [COUNT_W-1:0]  emit_next;
  logic [COUNT_W-1:0]  stack_diff;
  logic                out_load;

  // bucket count is a power of two, so the hash is a plain bit slice
  assign in_bucket    = in_key_i[HASH_SHIFT +: BUCKET_W];
  assign in_limit_sat = (in_limit_i > COUNT_W'(NUM_THREADS)) ? COUNT_W'(NUM_THREADS)
                                                             : in_limit_i;

  // first step of a walk uses the bucket head, later steps the fetched link
  assign cur        = use_link_q ? link_rd_q : head_rd_q;
  assign cur_end    = (cur >= LINK_NONE);
  assign head_we    = cmd_i.park | cmd_i.head_wb;
  assign head_wdata = cmd_i.park ? LINK_W'(tid_q) : (cur_end ? LINK_NONE : cur);
  assign emit_next  = emit_q + COUNT_W'(1);
  // release stack is read back from the top: last popped goes out first
  assign stack_diff = count_q - emit_next;
  assign out_load   = cmd_i.emit_ld | cmd_i.emit_none;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    if (cmd_i.capture) begin
      head_rd_q <= head_vld_q[in_bucket] ? head_mem[in_bucket] : LINK_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
    end else if (head_we) begin
      head_vld_q[bucket_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.park) begin
      link_mem[tid_q] <= head_rd_q;
    end
    if (cmd_i.walk_step) begin
      link_rd_q <= link_mem[cur[THREAD_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      stack_mem[count_q[THREAD_W-1:0]] <= cur[THREAD_W-1:0];
    end
    if (cmd_i.emit_rd) begin
      stack_rd_q <= stack_mem[stack_diff[THREAD_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bucket_q   <= in_bucket;
      tid_q      <= in_tid_i;
      limit_q    <= in_limit_sat;
      count_q    <= '0;
      emit_q     <= '0;
      use_link_q <= 1'b0;
    end else begin
      if (cmd_i.walk_step) begin
        count_q    <= count_q + COUNT_W'(1);
        use_link_q <= 1'b1;
      end
      if (cmd_i.emit_ld) begin
        emit_q <= emit_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_thread_q <= stack_rd_q;
      out_none_q   <= 1'b0;
      out_count_q  <= emit_next;
      out_last_q   <= (emit_next == count_q);
    end else if (cmd_i.emit_none) begin
      out_thread_q <= '0;
      out_none_q   <= 1'b1;
      out_count_q  <= '0;
      out_last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.walk_done  = (count_q == limit_q) || cur_end;
    sts_o.count_zero = (count_q == '0);
    sts_o.emit_last  = (emit_next == count_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_thread_o = out_thread_q;
  assign out_none_o   = out_none_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

FILE: design/address_keyed_wait_queue_unit.sv
// top level of the address keyed wait queue unit: stream ports, sequencer and datapath
// depends on akwq_pkg, akwq_ctrl, akwq_dp and address_keyed_wait_queue_unit_defines.svh
//
//   port group | dir | tdata (low bit up)                          | side bands
//   s_axis     | in  | key_address, thread_id, wake_limit, zero pad | tuser = op
//   m_axis     | out | woken_thread, woken_count, zero pad          | tuser = none_woken,
//              |     |                                              | tlast = last
//
// a wait is the item capture with bucket head read, then the push
// a wake that wakes nothing is the capture, the head write back and the empty result;
// else the chain walk pops one link a cycle through the link table port, the head is
// written back, then each result takes a release stack read and an output load
// reset leaves the head table empty at once through one valid bit per bucket
// one output register: the next item is taken while a result waits; a result
// that finds the register full holds the sequencer until m_axis_tready
`default_nettype none

`include "address_keyed_wait_queue_unit_defines.svh"

module address_keyed_wait_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key_address [63:0], thread_id [68:64], wake_limit [74:69], zero pad
  input  logic [akwq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // woken_thread [4:0], woken_count [10:5], zero pad
  output logic [akwq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // none_woken [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import akwq_pkg::*;

  akwq_cmd_t           cmd;
  akwq_sts_t           sts;
  logic [THREAD_W-1:0] out_thread;
  logic [COUNT_W-1:0]  out_count;
  logic [6:0]          cmd_vec;
  logic                in_fire;
  logic                none_ok;
  logic                woken_ok;

  akwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  akwq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_key_i     (s_axis_tdata[IN_KEY_LSB +: KEY_W]),
    .in_tid_i     (s_axis_tdata[IN_TID_LSB +: THREAD_W]),
    .in_limit_i   (s_axis_tdata[IN_LIMIT_LSB +: COUNT_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_thread_o (out_thread),
    .out_none_o   (m_axis_tuser),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_thread};

  assign cmd_vec = {cmd.capture, cmd.park, cmd.walk_step, cmd.head_wb,
                    cmd.emit_rd, cmd.emit_ld, cmd.emit_none};

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign none_ok  = m_axis_tlast && (out_count == '0);
  assign woken_ok = (out_count != '0);

  `AKWQ_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "item taken while busy")
  `AKWQ_ASSERT(a_none_form, (m_axis_tvalid && m_axis_tuser) |-> none_ok, "bad empty wake result")
  `AKWQ_ASSERT(a_woken_count, (m_axis_tvalid && !m_axis_tuser) |-> woken_ok, "zero woken count")
  `AKWQ_ASSERT(a_single_command, $onehot0(cmd_vec), "more than one command")

endmodule

`default_nettype wire
